// ===== hdl/leaf_switch_learning_forwarder_assert.svh =====
// ----------------------------------------------------------------------------
// leaf_switch_learning_forwarder_assert
// Assertion macros shared by the forwarder modules.
// ----------------------------------------------------------------------------
`ifndef LEAF_SWITCH_LEARNING_FORWARDER_ASSERT_SVH
`define LEAF_SWITCH_LEARNING_FORWARDER_ASSERT_SVH

// Checks that a condition implies a consequence on the same edge.
`define LSF_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Checks that a condition implies a consequence on the next edge.
`define LSF_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, codes and defaults for the leaf switch learning forwarder.
// ----------------------------------------------------------------------------
package lsf_pkg;

   localparam int QueueDepthDefault = 16;
   localparam int TableDepthDefault = 32;
   localparam int MaxSpinesDefault  = 8;
   localparam int HostCap           = 8;

   localparam logic [1:0] CSR_HOSTS  = 2'd0;
   localparam logic [1:0] CSR_SPINES = 2'd1;
   localparam logic [1:0] CSR_LIMIT  = 2'd2;

   localparam logic OP_ARRIVAL  = 1'b0;
   localparam logic OP_COMPLETE = 1'b1;

   localparam logic [2:0] ACT_QUEUED    = 3'd0;
   localparam logic [2:0] ACT_DROP_FULL = 3'd1;
   localparam logic [2:0] ACT_TO_HOST   = 3'd2;
   localparam logic [2:0] ACT_TO_SPINE  = 3'd3;
   localparam logic [2:0] ACT_DROP_UNK  = 3'd4;
   localparam logic [2:0] ACT_IDLE      = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [3:0]  arrival_port;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [7:0]  hop_in;
      logic [15:0] packet_tag;
      logic [2:0]  spine_pick;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  out_port;
      logic [15:0] tag_out;
      logic [7:0]  hop_out;
      logic [4:0]  queue_length;
      logic [31:0] spine_usage;
   } rsp_type;

   // Descriptor handed from the front part to the processing back part.
   typedef struct packed {
      logic        process;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [3:0]  port;
      logic [7:0]  hop;
      logic [15:0] tag;
      logic [2:0]  pick;
      logic [4:0]  queue_length;
   } job_type;

endpackage

// ===== hdl/lsf_ram.sv =====
// ----------------------------------------------------------------------------
// lsf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsf_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ===== hdl/lsf_front.sv =====
// ----------------------------------------------------------------------------
// lsf_front
// Descriptor queue and admission: queues arrivals, pops the head for the
// processor and sets the action code of queued or dropped events itself.
// ----------------------------------------------------------------------------
module lsf_front
   import lsf_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  req_type       req,
   input  logic [4:0]    limit,
   output logic          job_valid,
   output job_type       job
);
   localparam int QW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CW = $clog2(QueueDepth + 1);
   localparam int DW = 48 + 48 + 4 + 8 + 16;

   logic [QW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0] count_ff, count_in, eff_limit;
   logic          busy_ff, busy_in;
   logic          wr_en, pop;
   logic [DW-1:0] rd_data;
   logic          job_valid_ff;
   logic          fwd_ff;
   req_type       req_ff;
   logic [2:0]    act_ff;
   logic [CW-1:0] qlen_ff;
   logic          pop_ff;
   logic [DW-1:0] byp_ff;

   function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] v);
      logic [QW-1:0] r;
      if (int'(v) + 1 >= QueueDepth) begin
         r = '0;
      end else begin
         r = v + QW'(1);
      end
      return r;
   endfunction

   always_comb begin
      eff_limit = (int'(limit) > QueueDepth) ? CW'(QueueDepth) : CW'(limit);
      wr_en   = 1'b0;
      pop     = 1'b0;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      if (take) begin
         if (req.opcode == OP_ARRIVAL) begin
            if (count_ff < eff_limit) begin
               wr_en   = 1'b1;
               tail_in = wrap_inc(tail_ff);
               if (!busy_ff) begin
                  // Idle processor takes the new item straight away.
                  pop     = 1'b1;
                  busy_in = 1'b1;
                  head_in = wrap_inc(head_ff);
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
         end else begin
            busy_in = 1'b0;
            if (count_ff != '0) begin
               pop      = 1'b1;
               busy_in  = 1'b1;
               head_in  = wrap_inc(head_ff);
               count_in = count_ff - CW'(1);
            end
         end
      end
   end

   lsf_ram #(.Width(DW), .Depth(QueueDepth)) u_queue (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data({req.src_mac, req.dst_mac, req.arrival_port, req.hop_in, req.packet_tag}),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         job_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         job_valid_ff <= take;
      end
      req_ff  <= req;
      pop_ff  <= pop;
      // A pop of the entry written this same edge reads it from the bypass.
      fwd_ff  <= wr_en && (tail_ff == head_ff);
      byp_ff  <= {req.src_mac, req.dst_mac, req.arrival_port, req.hop_in, req.packet_tag};
      qlen_ff <= count_in;
      if (req.opcode == OP_ARRIVAL) begin
         act_ff <= wr_en ? ACT_QUEUED : ACT_DROP_FULL;
      end else begin
         act_ff <= ACT_IDLE;
      end
   end

   logic [DW-1:0] head_data;
   assign head_data = fwd_ff ? byp_ff : rd_data;

   always_comb begin
      job.process      = pop_ff;
      job.src_mac      = head_data[DW-1 -: 48];
      job.port         = head_data[27:24];
      job.tag          = pop_ff ? head_data[15:0]
                       : ((act_ff == ACT_IDLE) ? 16'd0 : req_ff.packet_tag);
      job.pick         = req_ff.spine_pick;
      job.queue_length = 5'(qlen_ff);
      job.hop          = pop_ff ? head_data[23:16] : 8'd0;
      job.dst_mac      = pop_ff ? head_data[DW-49 -: 48] : {8'd0, 37'd0, act_ff};
   end

   assign job_valid = job_valid_ff;

`include "leaf_switch_learning_forwarder_assert.svh"
   `LSF_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, int'(count_ff) <= QueueDepth,
                   "queue overflow")
   `LSF_ASSERT_IMP(a_pop_nonempty, clock, reset, take && req.opcode == OP_COMPLETE && pop,
                   count_ff != '0, "pop from empty queue")
   `LSF_ASSERT_NEXT(a_job_follows, clock, reset, take, job_valid, "event lost")
endmodule

// ===== hdl/lsf_back.sv =====
// ----------------------------------------------------------------------------
// lsf_back
// Processor: learns host source MACs into the table, looks up the destination
// and picks the egress port. Lookup is combinational; learning is registered.
// ----------------------------------------------------------------------------
module lsf_back
   import lsf_pkg::*;
#(
   parameter int TableDepth = TableDepthDefault,
   parameter int MaxSpines  = MaxSpinesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   input  logic [3:0] hosts,
   input  logic [3:0] spines,
   output logic       rsp_strobe,
   output rsp_type    rsp
);
   localparam int TW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
   localparam int SW = (MaxSpines > 1) ? $clog2(MaxSpines) : 1;

   logic [47:0]         key_ff  [TableDepth];
   logic [2:0]          tport_ff[TableDepth];
   logic [TableDepth-1:0] valid_ff;
   logic [31:0]         usage_ff[MaxSpines];

   logic [3:0]  eff_hosts;
   logic [4:0]  eff_spines;
   logic        from_host;
   logic        src_hit, dst_hit, has_free, learn;
   logic [TW-1:0] free_idx, dst_idx;
   logic [2:0]  dst_port;
   logic [SW-1:0] pick;
   logic [4:0]  pick_w;
   logic [7:0]  hop_inc;
   rsp_type     rsp_in;
   logic        strobe_ff;
   rsp_type     rsp_ff;

   always_comb begin
      eff_hosts  = (hosts > 4'(HostCap)) ? 4'(HostCap) : hosts;
      if (spines == 4'd0) begin
         eff_spines = 5'd1;
      end else if (int'(spines) > MaxSpines) begin
         eff_spines = 5'(MaxSpines);
      end else begin
         eff_spines = {1'b0, spines};
      end
      from_host = job.port < eff_hosts;
      src_hit = 1'b0;
      dst_hit = 1'b0;
      has_free = 1'b0;
      free_idx = '0;
      dst_idx  = '0;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == job.src_mac) src_hit = 1'b1;
         if (!valid_ff[i]) begin
            has_free = 1'b1;
            free_idx = TW'(i);
         end
      end
      learn = job_valid && job.process && from_host && !src_hit && has_free;
      for (int i = TableDepth - 1; i >= 0; i--) begin
         if (valid_ff[i] && key_ff[i] == job.dst_mac) begin
            dst_hit = 1'b1;
            dst_idx = TW'(i);
         end
      end
      dst_port = tport_ff[dst_idx];
      // A learned entry that lands in a slot before any match still wins.
      if (learn && job.src_mac == job.dst_mac && (!dst_hit || free_idx < dst_idx)) begin
         dst_hit  = 1'b1;
         dst_port = job.port[2:0];
      end
      pick_w = {2'd0, job.pick};
      if (pick_w > eff_spines - 5'd1) pick_w = eff_spines - 5'd1;
      pick = SW'(pick_w);
      hop_inc = (job.hop == 8'hFF) ? 8'hFF : job.hop + 8'd1;

      rsp_in.queue_length = job.queue_length;
      rsp_in.tag_out      = job.tag;
      rsp_in.out_port     = 4'd0;
      rsp_in.hop_out      = 8'd0;
      rsp_in.spine_usage  = 32'd0;
      if (!job.process) begin
         rsp_in.action = job.dst_mac[2:0];
      end else begin
         rsp_in.hop_out = hop_inc;
         if (dst_hit) begin
            rsp_in.action   = ACT_TO_HOST;
            rsp_in.out_port = {1'b0, dst_port};
         end else if (from_host) begin
            rsp_in.action      = ACT_TO_SPINE;
            rsp_in.out_port    = eff_hosts + 4'(pick_w);
            rsp_in.spine_usage = usage_ff[pick] + 32'd1;
         end else begin
            rsp_in.action = ACT_DROP_UNK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < MaxSpines; i++) usage_ff[i] <= '0;
      end else begin
         strobe_ff <= job_valid;
         if (learn) valid_ff[free_idx] <= 1'b1;
         if (job_valid && job.process && !dst_hit && from_host) begin
            usage_ff[pick] <= usage_ff[pick] + 32'd1;
         end
      end
      if (learn) begin
         key_ff[free_idx]   <= job.src_mac;
         tport_ff[free_idx] <= job.port[2:0];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;

`include "leaf_switch_learning_forwarder_assert.svh"
   `LSF_ASSERT_NEXT(a_rsp_follows, clock, reset, job_valid, rsp_strobe, "result lost")
   `LSF_ASSERT_IMP(a_learn_room, clock, reset, learn, !valid_ff[free_idx], "learn into used slot")
   `LSF_ASSERT_IMP(a_spine_port, clock, reset, rsp_strobe && rsp.action == ACT_TO_SPINE, rsp.spine_usage != 32'd0 || $past(usage_ff[0]) == 32'hFFFFFFFF || MaxSpines > 1, "spine usage")
endmodule

// ===== hdl/leaf_switch_learning_forwarder.sv =====
// ----------------------------------------------------------------------------
// leaf_switch_learning_forwarder
// Learning leaf switch: queues packet descriptors and forwards the head to a
// learned host port or a spine uplink.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// req_      in         start, busy
// rsp_      out        rsp_strobe, one cycle
// csr_      in         csr_wr_en, no wait
//
// An event is taken when start is high and busy low; it is registered as a job
// in the front part and its result is registered in the back part, with the
// result strobe. busy stays high after an accepted event through the cycle of
// its result strobe; that hold-off covers the queue RAM read and the table stage.
// Reset is synchronous and clears the queue pointers, table and counters.
// The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
module leaf_switch_learning_forwarder
   import lsf_pkg::*;
#(
   parameter int QueueDepth = QueueDepthDefault,
   parameter int TableDepth = TableDepthDefault,
   parameter int MaxSpines  = MaxSpinesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_strobe,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [4:0] csr_data
);
   logic [3:0] hosts_ff, spines_ff;
   logic [4:0] limit_ff;
   logic       take;
   logic       job_valid;
   job_type    job;
   logic [1:0] busy_ff;

   assign take = start && !busy;
   assign busy = busy_ff != 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         hosts_ff  <= 4'd4;
         spines_ff <= 4'd4;
         limit_ff  <= 5'd16;
         busy_ff   <= '0;
      end else begin
         busy_ff <= {busy_ff[0], take};
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_HOSTS:  hosts_ff  <= csr_data[3:0];
               CSR_SPINES: spines_ff <= csr_data[3:0];
               CSR_LIMIT:  limit_ff  <= csr_data;
               default: ;
            endcase
         end
      end
   end

   lsf_front #(.QueueDepth(QueueDepth)) u_front (
      .clock(clock), .reset(reset), .take(take), .req(req_data),
      .limit(limit_ff), .job_valid(job_valid), .job(job)
   );

   lsf_back #(.TableDepth(TableDepth), .MaxSpines(MaxSpines)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .hosts(hosts_ff), .spines(spines_ff), .rsp_strobe(rsp_strobe), .rsp(rsp_data)
   );
endmodule
